/* sv/vnorm_pkg.sv */
// Package: shared widths, register indexes and reset values for the normalizer.
package vnorm_pkg;
   localparam int COMPONENT_BITS_DEF = 16;
   localparam int FRACTION_BITS_DEF  = 12;
   localparam int THRESH_BITS        = 34;
   localparam int COUNT_BITS         = 3;
   localparam int CSR_DATA_BITS      = 34;
   localparam int CSR_INDEX_BITS     = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NUM_COMPONENTS = 1'b0,
      CSR_ZERO_THRESHOLD = 1'b1
   } csr_index_type;

   localparam logic [COUNT_BITS-1:0] NUM_COMPONENTS_RESET = 3'd4;
   localparam logic [THRESH_BITS-1:0] ZERO_THRESHOLD_RESET = 34'd2;
endpackage

/* sv/vnorm_sqrt.sv */
// Pipelined integer square root: one result bit per stage.
module vnorm_sqrt #(
   parameter int IN_BITS  = 34,
   parameter int TAG_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [IN_BITS-1:0]    in_value,
   input  logic [TAG_BITS-1:0]   in_tag,
   output logic                  out_valid,
   output logic [(IN_BITS+1)/2-1:0] out_root,
   output logic [TAG_BITS-1:0]   out_tag
);
   localparam int RB = (IN_BITS + 1) / 2;
   localparam int VB = 2 * RB;

   logic          valid_ff [RB+1];
   logic [VB-1:0] rem_ff   [RB+1];
   logic [RB-1:0] root_ff  [RB+1];
   logic [TAG_BITS-1:0] tag_ff [RB+1];

   always_comb begin
      valid_ff[0] = in_valid;
      rem_ff[0]   = VB'(in_value);
      root_ff[0]  = '0;
      tag_ff[0]   = in_tag;
   end

   // Stage k decides root bit RB-1-k by trial subtraction of (2r + 2^b) << b.
   for (genvar k = 0; k < RB; k++) begin : g_st
      localparam int B = RB - 1 - k;
      logic [VB-1:0] trial_in;
      logic [VB-1:0] rem_in;
      logic [RB-1:0] root_in;
      logic          valid_reg_ff;
      logic [VB-1:0] rem_reg_ff;
      logic [RB-1:0] root_reg_ff;
      logic [TAG_BITS-1:0] tag_reg_ff;
      always_comb begin
         trial_in = ((VB'(root_ff[k]) << 1) | (VB'(1) << B)) << B;
         rem_in   = rem_ff[k];
         root_in  = root_ff[k];
         if (rem_ff[k] >= trial_in) begin
            rem_in  = rem_ff[k] - trial_in;
            root_in = root_ff[k] | (RB'(1) << B);
         end
      end
      // root_ff holds the bits above B already placed at their weights.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_reg_ff <= 1'b0;
         end else if (advance) begin
            valid_reg_ff <= valid_ff[k];
         end
         if (advance) begin
            rem_reg_ff  <= rem_in;
            root_reg_ff <= root_in;
            tag_reg_ff  <= tag_ff[k];
         end
      end
      always_comb begin
         valid_ff[k+1] = valid_reg_ff;
         rem_ff[k+1]   = rem_reg_ff;
         root_ff[k+1]  = root_reg_ff;
         tag_ff[k+1]   = tag_reg_ff;
      end
   end

   assign out_valid = valid_ff[RB];
   assign out_root  = root_ff[RB];
   assign out_tag   = tag_ff[RB];
endmodule

/* sv/vnorm_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with saturation.
module vnorm_div #(
   parameter int COMPONENT_BITS = 16,
   parameter int FRACTION_BITS  = 12,
   parameter int DEN_BITS       = 17,
   parameter int TAG_BITS       = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [COMPONENT_BITS-1:0]  in_mag,
   input  logic                       in_neg,
   input  logic [DEN_BITS-1:0]        in_den,
   input  logic [TAG_BITS-1:0]        in_tag,
   output logic                       out_valid,
   output logic [COMPONENT_BITS-1:0]  out_value,
   output logic [TAG_BITS-1:0]        out_tag
);
   localparam int NB = COMPONENT_BITS + FRACTION_BITS;
   localparam int RW = DEN_BITS + 1;

   logic                valid_ff [NB+1];
   logic [NB-1:0]       num_ff   [NB+1];
   logic [RW-1:0]       rem_ff   [NB+1];
   logic [DEN_BITS-1:0] den_ff   [NB+1];
   logic                neg_ff   [NB+1];
   logic [TAG_BITS-1:0] tag_ff   [NB+1];

   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0]   = {in_mag, FRACTION_BITS'(0)};
      rem_ff[0]   = '0;
      den_ff[0]   = in_den;
      neg_ff[0]   = in_neg;
      tag_ff[0]   = in_tag;
   end

   // Numerator shifts left; quotient bits fill its low end.
   for (genvar k = 0; k < NB; k++) begin : g_st
      logic [RW-1:0] shifted;
      logic [RW-1:0] rem_in;
      logic [NB-1:0] num_in;
      logic          valid_reg_ff;
      logic [NB-1:0] num_reg_ff;
      logic [RW-1:0] rem_reg_ff;
      logic [DEN_BITS-1:0] den_reg_ff;
      logic          neg_reg_ff;
      logic [TAG_BITS-1:0] tag_reg_ff;
      always_comb begin
         shifted = {rem_ff[k][RW-2:0], num_ff[k][NB-1]};
         num_in  = {num_ff[k][NB-2:0], 1'b0};
         rem_in  = shifted;
         if (shifted >= RW'(den_ff[k])) begin
            rem_in    = shifted - RW'(den_ff[k]);
            num_in[0] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_reg_ff <= 1'b0;
         end else if (advance) begin
            valid_reg_ff <= valid_ff[k];
         end
         if (advance) begin
            num_reg_ff <= num_in;
            rem_reg_ff <= rem_in;
            den_reg_ff <= den_ff[k];
            neg_reg_ff <= neg_ff[k];
            tag_reg_ff <= tag_ff[k];
         end
      end
      always_comb begin
         valid_ff[k+1] = valid_reg_ff;
         num_ff[k+1]   = num_reg_ff;
         rem_ff[k+1]   = rem_reg_ff;
         den_ff[k+1]   = den_reg_ff;
         neg_ff[k+1]   = neg_reg_ff;
         tag_ff[k+1]   = tag_reg_ff;
      end
   end

   localparam logic [NB-1:0] POS_MAX = NB'((64'd1 << (COMPONENT_BITS - 1)) - 64'd1);
   localparam logic [NB-1:0] NEG_MAX = NB'(64'd1 << (COMPONENT_BITS - 1));

   logic [NB-1:0] q;
   logic [NB-1:0] q_sat;
   always_comb begin
      q = num_ff[NB];
      if (neg_ff[NB]) begin
         q_sat = (q > NEG_MAX) ? NEG_MAX : q;
         out_value = COMPONENT_BITS'(NB'(0) - q_sat);
      end else begin
         q_sat = (q > POS_MAX) ? POS_MAX : q;
         out_value = COMPONENT_BITS'(q_sat);
      end
   end
   assign out_valid = valid_ff[NB];
   assign out_tag   = tag_ff[NB];
endmodule

/* sv/vector4_normalizer_unit.sv */
// Top level: four-component fixed-point vector normalizer, fully pipelined.
//
// Usage:
//   req_ channel carries one input word: four signed components x,y,z,w.
//   rsp_ channel returns one word per input: four normalized components
//   and a skipped flag (tuser) set when the squared length is at or below
//   zero_threshold, in which case the inputs pass through unchanged.
//   csr_ port writes num_components (index 0) and zero_threshold (index 1);
//   write only while the pipeline is empty.
// Pipeline: square, pairwise-sum and total/compare stages, one square-root
//   stage per root bit, one divider stage per quotient bit, then the
//   output register.
// Throughput: one word per cycle unless the output stalls; each square-root
//   and divide stage resolves one bit, so the pipeline depth sets latency, not rate.
// Reset: clears all valid bits and loads num_components=4,
//   zero_threshold=2.
// Stall: when rsp_tready is low and the output register is full, the whole
//   pipeline holds; words already inside stay in place, and req_tready drops
//   only when the output register is full and stalled.
module vector4_normalizer_unit #(
   parameter int COMPONENT_BITS = vnorm_pkg::COMPONENT_BITS_DEF,
   parameter int FRACTION_BITS  = vnorm_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // comp_x, comp_y, comp_z, comp_w from lowest bit
   input  logic [4*COMPONENT_BITS-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // norm_x, norm_y, norm_z, norm_w from lowest bit
   output logic [4*COMPONENT_BITS-1:0]   rsp_tdata,
   // skipped
   output logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [vnorm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [vnorm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int CB  = COMPONENT_BITS;
   localparam int SQB = 2 * CB;          // one square, magnitude up to 2^(2CB-2)
   localparam int SB  = 2 * CB + 1;      // sum of four squares fits
   localparam int RB  = (SB + 1) / 2;    // root width
   localparam int TB  = vnorm_pkg::THRESH_BITS;
   localparam int CMPB = (SB > TB) ? SB : TB;
   localparam int TAGB = 4 * CB;

   // configuration
   logic [vnorm_pkg::COUNT_BITS-1:0] num_comp_ff;
   logic [TB-1:0]                    thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_comp_ff <= vnorm_pkg::NUM_COMPONENTS_RESET;
         thresh_ff   <= vnorm_pkg::ZERO_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (vnorm_pkg::csr_index_type'(csr_index))
            vnorm_pkg::CSR_NUM_COMPONENTS:
               num_comp_ff <= csr_wdata[vnorm_pkg::COUNT_BITS-1:0];
            vnorm_pkg::CSR_ZERO_THRESHOLD: thresh_ff <= csr_wdata[TB-1:0];
            default: ;
         endcase
      end
   end

   // Global stall: whole pipeline advances unless the output is full and held.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // Stage 1: magnitudes and squares
   logic            s1_valid_ff;
   logic [TAGB-1:0] s1_raw_ff;
   logic [SQB-1:0]  s1_sq_ff [4];
   logic [SQB-1:0]  sq_in [4];
   logic [3:0]      use_in;
   always_comb begin
      use_in[0] = 1'b1;
      use_in[1] = num_comp_ff > 3'd1;
      use_in[2] = num_comp_ff > 3'd2;
      use_in[3] = num_comp_ff > 3'd3;
      for (int i = 0; i < 4; i++) begin
         logic signed [CB-1:0] c;
         logic [CB-1:0] m;
         c = req_tdata[i*CB +: CB];
         m = c[CB-1] ? CB'(-c) : CB'(c);
         sq_in[i] = use_in[i] ? SQB'(m) * SQB'(m) : '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (advance) begin
         s1_raw_ff <= req_tdata;
         for (int i = 0; i < 4; i++) s1_sq_ff[i] <= sq_in[i];
      end
   end

   // Stage 2: pairwise sums
   logic            s2_valid_ff;
   logic [TAGB-1:0] s2_raw_ff;
   logic [SB-1:0]   s2_a_ff, s2_b_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_raw_ff <= s1_raw_ff;
         s2_a_ff   <= SB'(s1_sq_ff[0]) + SB'(s1_sq_ff[1]);
         s2_b_ff   <= SB'(s1_sq_ff[2]) + SB'(s1_sq_ff[3]);
      end
   end

   // Stage 3: total and threshold compare
   logic            s3_valid_ff;
   logic [TAGB-1:0] s3_raw_ff;
   logic [SB-1:0]   s3_sum_ff;
   logic            s3_skip_ff;
   logic [SB-1:0]   sum_in;
   assign sum_in = s2_a_ff + s2_b_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_raw_ff  <= s2_raw_ff;
         s3_sum_ff  <= sum_in;
         s3_skip_ff <= CMPB'(sum_in) <= CMPB'(thresh_ff);
      end
   end

   // Square root; skip flag rides along with the raw components.
   logic                sq_valid;
   logic [RB-1:0]       sq_root;
   logic [TAGB:0]       sq_tag;
   vnorm_sqrt #(.IN_BITS(SB), .TAG_BITS(TAGB + 1)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s3_valid_ff), .in_value(s3_sum_ff),
      .in_tag({s3_skip_ff, s3_raw_ff}),
      .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag));

   // Length is never zero when not skipped; force 1 to keep dividers sane.
   logic [RB-1:0] len;
   assign len = (sq_root == '0) ? RB'(1) : sq_root;

   logic [3:0]      dv_valid;
   logic [CB-1:0]   dv_value [4];
   logic [TAGB:0]   dv_tag [4];
   for (genvar i = 0; i < 4; i++) begin : g_div
      logic signed [CB-1:0] c;
      logic [CB-1:0] m;
      assign c = sq_tag[i*CB +: CB];
      assign m = c[CB-1] ? CB'(-c) : CB'(c);
      vnorm_div #(.COMPONENT_BITS(CB), .FRACTION_BITS(FRACTION_BITS),
                  .DEN_BITS(RB), .TAG_BITS(TAGB + 1)) u_div (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(sq_valid), .in_mag(m), .in_neg(c[CB-1]), .in_den(len),
         .in_tag(sq_tag), .out_valid(dv_valid[i]), .out_value(dv_value[i]),
         .out_tag(dv_tag[i]));
   end

   // Output register
   logic            out_valid_ff;
   logic [TAGB-1:0] out_data_ff;
   logic            out_skip_ff;
   logic [TAGB-1:0] norm_in;
   always_comb begin
      for (int i = 0; i < 4; i++) norm_in[i*CB +: CB] = dv_value[i];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid[0];
      end
      if (advance) begin
         out_skip_ff <= dv_tag[0][TAGB];
         out_data_ff <= dv_tag[0][TAGB] ? dv_tag[0][TAGB-1:0] : norm_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_skip_ff;

`ifndef SYNTH
   // Lanes of the divider bank stay in lockstep.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] == dv_valid[1] && dv_valid[0] == dv_valid[2] &&
      dv_valid[0] == dv_valid[3])
      else $error("divider lanes out of step");
   // A held output stays put while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");
   // An unskipped word never has a zero root.
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      sq_valid && !sq_tag[TAGB] |-> sq_root != '0)
      else $error("zero length on normalized word");
`endif
endmodule

/* verif/vector4_normalizer_unit_tb.sv */
// Testbench for the vector normalizer: predicted results checked against the stream output.
`timescale 1ns / 100ps

module vector4_normalizer_unit_tb;

   localparam int CB = 16;
   localparam int FB = 12;
   localparam int PIPE_LATENCY = 49;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [CB-1:0] w;
      logic [CB-1:0] z;
      logic [CB-1:0] y;
      logic [CB-1:0] x;
   } vec_word_type;

   typedef struct {
      vec_word_type norm;
      logic         skipped;
   } norm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [4*CB-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [4*CB-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [vnorm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [vnorm_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predictor copy of the registers
   logic [vnorm_pkg::COUNT_BITS-1:0]  cfg_count = vnorm_pkg::NUM_COMPONENTS_RESET;
   logic [vnorm_pkg::THRESH_BITS-1:0] cfg_thresh = vnorm_pkg::ZERO_THRESHOLD_RESET;

   norm_result_type pending_norms[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stall_enable = 1'b1;

   vector4_normalizer_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CB:0] comp_mag(input logic [CB-1:0] c);
      return c[CB-1] ? (CB+1)'(-$signed({c[CB-1], c})) : {1'b0, c};
   endfunction

   function automatic logic [CB-1:0] scale_comp(input logic [CB-1:0] c,
                                                 input logic [63:0] len);
      logic [63:0] q;
      q = ({47'b0, comp_mag(c)} << FB) / len;
      if (c[CB-1]) begin
         if (q > 64'(1 << (CB-1))) q = 64'(1 << (CB-1));
         return CB'(-q);
      end
      if (q > 64'((1 << (CB-1)) - 1)) q = 64'((1 << (CB-1)) - 1);
      return CB'(q);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
      return r;
   endfunction

   function automatic norm_result_type normalize(input vec_word_type v);
      norm_result_type res;
      logic [63:0] sum, len, m;
      logic [CB-1:0] c[4];
      c = '{v.x, v.y, v.z, v.w};
      sum = 0;
      for (int i = 0; i < 4; i++)
         if (i == 0 || cfg_count > i) begin
            m = 64'(comp_mag(c[i]));
            sum += m * m;
         end
      if (sum <= 64'(cfg_thresh)) begin
         res.norm = v;
         res.skipped = 1'b1;
      end else begin
         len = int_sqrt(sum);
         res.norm.x = scale_comp(v.x, len);
         res.norm.y = scale_comp(v.y, len);
         res.norm.z = scale_comp(v.z, len);
         res.norm.w = scale_comp(v.w, len);
         res.skipped = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [CB-1:0] got,
                                  input logic [CB-1:0] want);
      $display("tb: mismatch %s got %h want %h", what, got, want);
      error_count++;
   endtask

   // sends one word; the sender gaps at random between words
   task automatic send_vec(input vec_word_type v);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_norms.push_back(normalize(v));
      if ($urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      end_burst();
      while (pending_norms.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input vnorm_pkg::csr_index_type idx,
                            input logic [vnorm_pkg::CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == vnorm_pkg::CSR_NUM_COMPONENTS) cfg_count = val[vnorm_pkg::COUNT_BITS-1:0];
      else cfg_thresh = val[vnorm_pkg::THRESH_BITS-1:0];
   endtask

   function automatic vec_word_type rand_vec();
      vec_word_type v;
      v = {$urandom, $urandom};
      // small magnitudes now and then, to reach the skip path and large quotients
      if ($urandom_range(0, 3) == 0) begin
         v.x = CB'($signed($urandom_range(0, 8)) - 4);
         v.y = CB'($signed($urandom_range(0, 8)) - 4);
         v.z = CB'($signed($urandom_range(0, 8)) - 4);
      end
      return v;
   endfunction

   task automatic test_directed();
      send_vec('{w: 16'h0000, z: 16'h0000, y: 16'h0000, x: 16'h0000});
      send_vec('{w: 16'h0000, z: 16'h0000, y: 16'h0000, x: 16'h0001});
      send_vec('{w: 16'h0000, z: 16'h0000, y: 16'h0001, x: 16'h0001});
      send_vec('{w: 16'h0000, z: 16'h0000, y: 16'h0000, x: 16'h0002});
      send_vec('{w: 16'h7fff, z: 16'h7fff, y: 16'h7fff, x: 16'h7fff});
      send_vec('{w: 16'h8000, z: 16'h8000, y: 16'h8000, x: 16'h8000});
      send_vec('{w: 16'h8000, z: 16'h7fff, y: 16'h0000, x: 16'h1000});
      send_vec('{w: 16'hffff, z: 16'h0001, y: 16'hffff, x: 16'h0001});
      send_vec('{w: 16'h7fff, z: 16'h8000, y: 16'h0000, x: 16'h0001});
      send_vec('{w: 16'h1000, z: 16'h0000, y: 16'h0000, x: 16'h0000});
      send_vec('{w: 16'h0000, z: 16'h0000, y: 16'h1000, x: 16'hf000});
      drain();
   endtask

   task automatic test_counts();
      // count of zero acts as one, five to seven as four
      for (int n = 0; n < 8; n++) begin
         write_csr(vnorm_pkg::CSR_NUM_COMPONENTS, vnorm_pkg::CSR_DATA_BITS'(n));
         send_vec('{w: 16'h8000, z: 16'h0003, y: 16'hfffe, x: 16'h0001});
         send_vec('{w: 16'h7fff, z: 16'h0000, y: 16'h0000, x: 16'h0000});
         drain();
      end
   endtask

   task automatic test_thresholds();
      logic [vnorm_pkg::CSR_DATA_BITS-1:0] levels[5];
      levels = '{34'd0, 34'd1, 34'h3ffffffff, 34'd4096, 34'h40000000};
      write_csr(vnorm_pkg::CSR_NUM_COMPONENTS, 34'd4);
      foreach (levels[i]) begin
         write_csr(vnorm_pkg::CSR_ZERO_THRESHOLD, levels[i]);
         for (int k = 0; k < 40; k++) send_vec(rand_vec());
         drain();
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(vnorm_pkg::CSR_NUM_COMPONENTS,
                   vnorm_pkg::CSR_DATA_BITS'($urandom_range(0, 7)));
         write_csr(vnorm_pkg::CSR_ZERO_THRESHOLD,
                   ($urandom_range(0, 1) != 0)
                      ? vnorm_pkg::CSR_DATA_BITS'($urandom_range(0, 64))
                      : vnorm_pkg::CSR_DATA_BITS'({$urandom, $urandom}));
         for (int k = 0; k < 160; k++) send_vec(rand_vec());
         // hold off until the pipeline has emptied, then resume the phase
         end_burst();
         while (pending_norms.size() != 0) @(posedge clock);
         for (int k = 0; k < 20; k++) send_vec(rand_vec());
         drain();
      end
   endtask

   // receiver stall pattern: always ready while stalls are off, else ready at random each cycle
   always @(posedge clock) begin
      if (!stall_enable) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 200 / 3) || ($urandom_range(0, 3) == 0);
   end

   // result checker
   always @(posedge clock) begin
      norm_result_type want;
      vec_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_norms.size() == 0) begin
            report_mismatch("unexpected word", got.x, CB'(0));
         end else begin
            want = pending_norms.pop_front();
            if (got.x !== want.norm.x) report_mismatch("norm_x", got.x, want.norm.x);
            if (got.y !== want.norm.y) report_mismatch("norm_y", got.y, want.norm.y);
            if (got.z !== want.norm.z) report_mismatch("norm_z", got.z, want.norm.z);
            if (got.w !== want.norm.w) report_mismatch("norm_w", got.w, want.norm.w);
            if (rsp_tuser !== want.skipped)
               report_mismatch("skipped", CB'(rsp_tuser), CB'(want.skipped));
         end
      end
   end

   // watchdog on cycles with no handshake on either channel and no register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stall-free stretches of random length at random intervals
   initial begin
      forever begin
         repeat ($urandom_range(200, 800)) @(posedge clock);
         stall_enable = 1'b0;
         repeat ($urandom_range(50, 200)) @(posedge clock);
         stall_enable = 1'b1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_counts();
      test_thresholds();
      test_random();
      write_csr(vnorm_pkg::CSR_NUM_COMPONENTS, 34'd4);
      write_csr(vnorm_pkg::CSR_ZERO_THRESHOLD, 34'd2);
      for (int k = 0; k < 30; k++) send_vec(rand_vec());
      drain();
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
